/* rtl/pfr_pkg.sv */
// Shared types and constants of the 16 bpp pattern fill engine.
package pfr_pkg;

  localparam int PATTERN_ROWS = 16;
  localparam int ROW_W        = $clog2(PATTERN_ROWS);
  localparam int PAT_W        = 16;
  localparam int COL_W        = $clog2(PAT_W);
  localparam int COORD_W      = 12;
  localparam int PIX_W        = 16;
  localparam int ADDR_W       = 32;
  localparam int STRIDE_W     = 16;
  localparam int MODE_W       = 3;
  localparam int PROD_W       = COORD_W + STRIDE_W;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [COL_W-1:0] PAT_MSB = COL_W'(PAT_W - 1);

  // Writing modes; every other code writes nothing.
  localparam logic [MODE_W-1:0] MODE_REPLACE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSPARENT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_XOR         = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVTRANSP   = 3'd4;

  // Item opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]   write_mode;
    logic [PIX_W-1:0]    fore_colour;
    logic [PIX_W-1:0]    back_colour;
    logic [ADDR_W-1:0]   frame_base;
    logic [STRIDE_W-1:0] row_stride_words;
  } cfg_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    logic               is_pixel;
    logic               pat_bit;
    logic [PROD_W-1:0]  row_offset;
    logic [COORD_W-1:0] pixel_x;
    logic [PIX_W-1:0]   old_pixel;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/pfr_if.sv */
// Handshake channel interfaces for pixel items and write results.
interface pfr_in_if;
  import pfr_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [ROW_W-1:0]    pattern_row;
  logic [PAT_W-1:0]    pattern_bits;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [PIX_W-1:0]    old_pixel;

  modport source (output valid, opcode, pattern_row, pattern_bits, pixel_x, pixel_y,
                  old_pixel, input ready);
  modport sink (input valid, opcode, pattern_row, pattern_bits, pixel_x, pixel_y,
                old_pixel, output ready);
endinterface

interface pfr_out_if;
  import pfr_pkg::*;
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [ADDR_W-1:0]  write_address;
  logic [PIX_W-1:0]   write_value;

  modport source (output valid, write_enable, write_address, write_value, input ready);
  modport sink (input valid, write_enable, write_address, write_value, output ready);
endinterface

/* rtl/pfr_front.sv */
// Front end: holds the pattern store, picks the pattern bit and forms y * stride.
module pfr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           opcode,
  input  logic [pfr_pkg::ROW_W-1:0]      pattern_row,
  input  logic [pfr_pkg::PAT_W-1:0]      pattern_bits,
  input  logic [pfr_pkg::COORD_W-1:0]    pixel_x,
  input  logic [pfr_pkg::COORD_W-1:0]    pixel_y,
  input  logic [pfr_pkg::PIX_W-1:0]      old_pixel,
  input  logic [pfr_pkg::STRIDE_W-1:0]   row_stride_words,
  output pfr_pkg::qent_t                 entry
);
  import pfr_pkg::*;

  logic [PAT_W-1:0] pattern_store [PATTERN_ROWS];
  logic [PAT_W-1:0] row_word;
  logic [COL_W-1:0] bit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < PATTERN_ROWS; r++) begin
        pattern_store[r] <= '0;
      end
    end else if (accept && opcode == OP_LOAD) begin
      pattern_store[pattern_row] <= pattern_bits;
    end
  end

  // Row is y mod 16, column bit 15 is the leftmost pixel.
  assign row_word = pattern_store[pixel_y[ROW_W-1:0]];
  assign bit_idx  = PAT_MSB - pixel_x[COL_W-1:0];

  always_comb begin
    entry.is_pixel   = (opcode == OP_PIXEL);
    entry.pat_bit    = row_word[bit_idx];
    entry.row_offset = PROD_W'(pixel_y) * PROD_W'(row_stride_words);
    entry.pixel_x    = pixel_x;
    entry.old_pixel  = old_pixel;
  end

endmodule

/* rtl/pfr_queue.sv */
// Short queue of classified items between the front and back ends.
module pfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfr_pkg::qent_t  push_data,
  input  logic            pop,
  output pfr_pkg::qent_t  pop_data,
  output pfr_pkg::qstat_t stat
);
  import pfr_pkg::*;

  qent_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

/* rtl/pfr_back.sv */
// Back end: forms the word address, applies the writing mode, holds the result.
module pfr_back (
  input  logic            clk,
  input  logic            rst,
  input  pfr_pkg::cfg_t   cfg,
  input  pfr_pkg::qent_t  entry,
  input  logic            entry_valid,
  output logic            pop,
  pfr_out_if.source       out
);
  import pfr_pkg::*;

  logic              we_next;
  logic [ADDR_W-1:0] addr_next;
  logic [PIX_W-1:0]  val_next;

  assign pop = entry_valid && (!out.valid || out.ready);

  always_comb begin
    we_next   = 1'b0;
    val_next  = '0;
    addr_next = '0;
    if (entry.is_pixel) begin
      addr_next = cfg.frame_base + ADDR_W'(entry.row_offset) + ADDR_W'(entry.pixel_x);
      unique case (cfg.write_mode)
        MODE_REPLACE: begin
          we_next  = 1'b1;
          val_next = entry.pat_bit ? cfg.fore_colour : cfg.back_colour;
        end
        MODE_TRANSPARENT: begin
          we_next  = entry.pat_bit;
          val_next = entry.pat_bit ? cfg.fore_colour : '0;
        end
        MODE_XOR: begin
          we_next  = entry.pat_bit;
          val_next = entry.pat_bit ? ~entry.old_pixel : '0;
        end
        MODE_REVTRANSP: begin
          we_next  = !entry.pat_bit;
          val_next = entry.pat_bit ? '0 : cfg.fore_colour;
        end
        default: begin
          we_next  = 1'b0;
          val_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (pop) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out.write_enable  <= we_next;
      out.write_address <= addr_next;
      out.write_value   <= val_next;
    end
  end

endmodule

/* rtl/pattern_fill_pixel_rop16.sv */
// Top level of the 16 bpp pattern fill engine with its configuration registers.
// Path of an item: the accepting edge writes the queue (pattern lookup and y * stride multiply),
// and the output register loads from the queue whenever it is empty or its result is taken.
// Throughput: one item per cycle; input ready drops only when the four-entry queue is full.
// Reset (rst, synchronous): pattern store cleared, queue emptied, output not valid,
// registers back to replace mode, white foreground, black background, base 0, stride 640.
module pattern_fill_pixel_rop16 (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  pfr_in_if.sink                           in,
  pfr_out_if.source                        out
);
  import pfr_pkg::*;

  cfg_t   cfg;
  qent_t  front_entry;
  qent_t  back_entry;
  qstat_t qstat;
  logic   accept;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_mode       <= MODE_REPLACE;
      cfg.fore_colour      <= '1;
      cfg.back_colour      <= '0;
      cfg.frame_base       <= '0;
      cfg.row_stride_words <= STRIDE_W'(640);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WRITE_MODE:  cfg.write_mode       <= cfg_data[MODE_W-1:0];
        REG_FORE_COLOUR: cfg.fore_colour      <= cfg_data[PIX_W-1:0];
        REG_BACK_COLOUR: cfg.back_colour      <= cfg_data[PIX_W-1:0];
        REG_FRAME_BASE:  cfg.frame_base       <= cfg_data[ADDR_W-1:0];
        REG_ROW_STRIDE:  cfg.row_stride_words <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in.ready = !qstat.full;
  assign accept   = in.valid && in.ready;

  pfr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .opcode           (in.opcode),
    .pattern_row      (in.pattern_row),
    .pattern_bits     (in.pattern_bits),
    .pixel_x          (in.pixel_x),
    .pixel_y          (in.pixel_y),
    .old_pixel        (in.old_pixel),
    .row_stride_words (cfg.row_stride_words),
    .entry            (front_entry)
  );

  pfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_entry),
    .pop       (pop),
    .pop_data  (back_entry),
    .stat      (qstat)
  );

  pfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .entry       (back_entry),
    .entry_valid (!qstat.empty),
    .pop         (pop),
    .out         (out)
  );

endmodule

/* rtl/pfr_check.sv */
// Port-level checker for the pattern fill engine, bound to the top level.
module pfr_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_write_enable,
  input logic [pfr_pkg::ADDR_W-1:0]    out_write_address,
  input logic [pfr_pkg::PIX_W-1:0]     out_write_value
);
  import pfr_pkg::*;

  // A result that is not taken stays offered with the same address.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_write_address))
    else $error("stalled result was dropped or changed");

  // Every result that writes nothing carries a zero value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_write_enable |-> out_write_value == '0)
    else $error("non-writing result carries a value");

  // Reset empties the output register and the queue.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready straight after reset");

endmodule

bind pattern_fill_pixel_rop16 pfr_check u_pfr_check (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in.ready),
  .out_valid         (out.valid),
  .out_ready         (out.ready),
  .out_write_enable  (out.write_enable),
  .out_write_address (out.write_address),
  .out_write_value   (out.write_value)
);

/* bench/pfr_write_checker.sv */
// Checker that predicts the engine's framebuffer writes and compares them with its output.
module pfr_write_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data,
  pfr_in_if                              item_ch,
  pfr_out_if                             wr_ch,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfr_pkg::*;

  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_value;
  } fb_write_t;

  cfg_t             shadow_cfg;
  logic [PAT_W-1:0] pattern_rows [PATTERN_ROWS];
  fb_write_t        expected_writes [$];

  function automatic fb_write_t predict_write(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                              logic [PIX_W-1:0] old);
    fb_write_t        w;
    logic [PAT_W-1:0] row_word;
    logic             hit;
    row_word = pattern_rows[y[ROW_W-1:0]];
    // Bit 15 of the row word is the leftmost column of the pattern.
    hit = row_word[PAT_MSB - x[COL_W-1:0]];
    w.write_address = shadow_cfg.frame_base
                    + ADDR_W'(y) * ADDR_W'(shadow_cfg.row_stride_words)
                    + ADDR_W'(x);
    w.write_enable = 1'b0;
    w.write_value  = '0;
    case (shadow_cfg.write_mode)
      MODE_REPLACE: begin
        w.write_enable = 1'b1;
        w.write_value  = hit ? shadow_cfg.fore_colour : shadow_cfg.back_colour;
      end
      MODE_TRANSPARENT: begin
        if (hit) begin
          w.write_enable = 1'b1;
          w.write_value  = shadow_cfg.fore_colour;
        end
      end
      MODE_XOR: begin
        if (hit) begin
          w.write_enable = 1'b1;
          w.write_value  = ~old;
        end
      end
      MODE_REVTRANSP: begin
        if (!hit) begin
          w.write_enable = 1'b1;
          w.write_value  = shadow_cfg.fore_colour;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (fail_count < MAX_REPORTS)
      $display("%0t ns checker: %s: got %h, wanted %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fb_write_t got;
    fb_write_t want;
    if (rst) begin
      shadow_cfg.write_mode       = MODE_REPLACE;
      shadow_cfg.fore_colour      = 16'hffff;
      shadow_cfg.back_colour      = 16'h0000;
      shadow_cfg.frame_base       = 32'h0000_0000;
      shadow_cfg.row_stride_words = 16'd640;
      for (int r = 0; r < PATTERN_ROWS; r++)
        pattern_rows[r] = '0;
      expected_writes.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WRITE_MODE:  shadow_cfg.write_mode       = cfg_data[MODE_W-1:0];
          REG_FORE_COLOUR: shadow_cfg.fore_colour      = cfg_data[PIX_W-1:0];
          REG_BACK_COLOUR: shadow_cfg.back_colour      = cfg_data[PIX_W-1:0];
          REG_FRAME_BASE:  shadow_cfg.frame_base       = cfg_data[ADDR_W-1:0];
          REG_ROW_STRIDE:  shadow_cfg.row_stride_words = cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      // The result of an item accepted at this edge cannot leave at the same edge,
      // so the output side is served before the new expectation is queued.
      if (wr_ch.valid && wr_ch.ready) begin
        got.write_enable  = wr_ch.write_enable;
        got.write_address = wr_ch.write_address;
        got.write_value   = wr_ch.write_value;
        if (expected_writes.size() == 0) begin
          report_mismatch("result with none expected", got.write_address, '0);
        end else begin
          want = expected_writes.pop_front();
          if (got.write_enable !== want.write_enable)
            report_mismatch("write_enable", ADDR_W'(got.write_enable),
                            ADDR_W'(want.write_enable));
          if (got.write_address !== want.write_address)
            report_mismatch("write_address", got.write_address, want.write_address);
          if (got.write_value !== want.write_value)
            report_mismatch("write_value", ADDR_W'(got.write_value), ADDR_W'(want.write_value));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.opcode == OP_LOAD) begin
          pattern_rows[item_ch.pattern_row] = item_ch.pattern_bits;
          expected_writes.push_back('0);
        end else begin
          expected_writes.push_back(predict_write(item_ch.pixel_x, item_ch.pixel_y,
                                                  item_ch.old_pixel));
        end
      end
    end
    pending = expected_writes.size();
  end

endmodule

/* bench/tb.sv */
// Testbench top for the pattern fill engine: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE_LOW  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NONE_HIGH = 3'd7;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int CHUNKS        = 3;
  localparam int CHUNK_ITEMS   = 45;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    fail_count;
  int                    pending;
  int                    stall_cycles;

  logic [MODE_W-1:0] probe_modes [5] = '{MODE_TRANSPARENT, MODE_XOR, MODE_REVTRANSP,
                                         MODE_NONE_LOW, MODE_NONE_HIGH};
  int send_pcts [3] = '{26, 65, 0};
  int recv_pcts [3] = '{65, 26, 0};

  pfr_in_if  item_ch ();
  pfr_out_if wr_ch ();

  pattern_fill_pixel_rop16 u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (item_ch),
    .out       (wr_ch)
  );

  pfr_write_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_ch    (item_ch),
    .wr_ch      (wr_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    wr_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      wr_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (wr_ch.valid && wr_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Entered at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so that a following item can go out without a gap.
  task automatic push_item(logic op, logic [ROW_W-1:0] row, logic [PAT_W-1:0] bits,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [PIX_W-1:0] old);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= op;
    item_ch.pattern_row  <= row;
    item_ch.pattern_bits <= bits;
    item_ch.pixel_x      <= x;
    item_ch.pixel_y      <= y;
    item_ch.old_pixel    <= old;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [PIX_W-1:0] old);
    push_item(OP_PIXEL, ROW_W'($urandom), PAT_W'($urandom), x, y, old);
  endtask

  task automatic send_load(logic [ROW_W-1:0] row, logic [PAT_W-1:0] bits);
    push_item(OP_LOAD, row, bits, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
  endtask

  // Drops valid, waits until every expected write has come out, then idles for SETTLE_CYCLES.
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Unused upper bits of each write carry random junk, which the engine must drop.
  task automatic program_regs(logic [MODE_W-1:0] mode, logic [PIX_W-1:0] fg,
                              logic [PIX_W-1:0] bg, logic [ADDR_W-1:0] base,
                              logic [STRIDE_W-1:0] stride);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    put_reg(REG_WRITE_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
    junk = $urandom;
    put_reg(REG_FORE_COLOUR, {junk[CFG_DATA_W-1:PIX_W], fg});
    junk = $urandom;
    put_reg(REG_BACK_COLOUR, {junk[CFG_DATA_W-1:PIX_W], bg});
    put_reg(REG_FRAME_BASE, base);
    junk = $urandom;
    put_reg(REG_ROW_STRIDE, {junk[CFG_DATA_W-1:STRIDE_W], stride});
    for (int i = REG_ROW_STRIDE + 1; i < 2 ** CFG_IDX_W; i++)
      put_reg(CFG_IDX_W'(i), $urandom);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(int width);
    logic [31:0] mask;
    mask = (width >= 32) ? '1 : ((32'd1 << width) - 1);
    case ($urandom_range(3))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  initial begin
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.opcode       = OP_LOAD;
    item_ch.pattern_row  = '0;
    item_ch.pattern_bits = '0;
    item_ch.pixel_x      = '0;
    item_ch.pixel_y      = '0;
    item_ch.old_pixel    = '0;
    send_idle_pct        = send_pcts[0];
    recv_idle_pct        = recv_pcts[0];
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // The pattern is empty after reset, so replace mode paints the background.
    send_pixel(12'd0, 12'd0, 16'h0000);
    send_load(4'd0, 16'h8000);
    send_load(4'd15, 16'hffff);
    send_load(4'd1, 16'h0001);
    send_load(4'd7, 16'h0000);
    send_pixel(12'd0, 12'd0, 16'hffff);
    send_pixel(12'hfff, 12'hfff, 16'h0000);
    send_pixel(12'd15, 12'd1, 16'h5a5a);
    send_pixel(12'd1, 12'd0, 16'ha5a5);
    foreach (probe_modes[i]) begin
      settle();
      program_regs(probe_modes[i], 16'hc3c3, 16'hffff, 32'h0000_0000, 16'd640);
      send_pixel(12'd0, 12'd0, 16'ha5a5);
      send_pixel(12'd1, 12'd0, 16'ha5a5);
    end
    // Address arithmetic at its extremes, wrapping past the top of the address space.
    settle();
    program_regs(MODE_REPLACE, 16'h0000, 16'hffff, 32'hffff_ffff, 16'hffff);
    send_pixel(12'hfff, 12'hfff, 16'h1234);
    send_pixel(12'd0, 12'd0, 16'h1234);
    settle();
    program_regs(MODE_XOR, 16'hffff, 16'h0000, 32'h0000_0000, 16'h0000);
    send_pixel(12'hfff, 12'hfff, 16'h0000);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_idle_pct = recv_pcts[ph];
      for (int c = 0; c < CHUNKS; c++) begin
        settle();
        program_regs(MODE_W'($urandom_range(7)), PIX_W'(pick_value(PIX_W)),
                     PIX_W'(pick_value(PIX_W)), pick_value(ADDR_W),
                     STRIDE_W'(pick_value(STRIDE_W)));
        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          if ($urandom_range(39) == 0)
            settle();
          push_item(($urandom_range(3) == 0) ? OP_LOAD : OP_PIXEL, ROW_W'($urandom),
                    PAT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                    PIX_W'($urandom));
        end
      end
    end
    settle();

    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
